// File: rtl/poly1305_mac_unit_defines.svh
// Assertion macros used by the checker file poly_checker.sv.
`ifndef POLY1305_MAC_UNIT_DEFINES_SVH
`define POLY1305_MAC_UNIT_DEFINES_SVH

// Clocked check, skipped while reset is asserted.
`define POLY_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define POLY_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/poly_pkg.sv
// ----------------------------------------------------------------------------
// poly_pkg
// Types, constants and helpers for the Poly1305 MAC unit.
// ----------------------------------------------------------------------------
package poly_pkg;

    localparam logic [25:0] LIMB_MASK   = 26'h3FFFFFF;
    localparam logic [63:0] R_CLAMP_LO  = 64'h0FFFFFFC0FFFFFFF;
    localparam logic [63:0] R_CLAMP_HI  = 64'h0FFFFFFC0FFFFFFC;
    localparam logic [25:0] TOP_BIT     = 26'h1000000;
    localparam logic [3:0]  MAX_BYTES   = 4'd8;
    localparam logic [4:0]  BLOCK_BYTES = 5'd16;

    localparam logic [2:0] CFG_R_LO = 3'd0;
    localparam logic [2:0] CFG_R_HI = 3'd1;
    localparam logic [2:0] CFG_S_LO = 3'd2;
    localparam logic [2:0] CFG_S_HI = 3'd3;

    typedef struct packed {
        logic [63:0] chunk_data;
        logic [3:0]  chunk_bytes;
        logic        last_chunk;
    } t_chunk;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } t_tag;

    // One unit of work for the back end: absorb a block, finish, or both.
    typedef struct packed {
        logic [127:0] blk;
        logic         absorb;
        logic         hibit;
        logic         fin;
    } t_cmd;

    typedef logic [4:0][25:0] t_limbs;

    typedef struct packed {
        logic [63:0] r_lo;
        logic [63:0] r_hi;
        logic [63:0] s_lo;
        logic [63:0] s_hi;
    } t_key;

    function automatic t_limbs split_limbs(input logic [63:0] lo, input logic [63:0] hi);
        t_limbs l;
        l[0] = lo[25:0];
        l[1] = lo[51:26];
        l[2] = {hi[13:0], lo[63:52]};
        l[3] = hi[39:14];
        l[4] = {2'b00, hi[63:40]};
        return l;
    endfunction

endpackage

// File: rtl/poly1305_mac_unit.sv
// The front end takes one chunk per cycle while the queue has room and no command is pending;
//   in the core each 16-byte block goes through pop, add, 25 products on one shared 27x29
//   multiplier, a drain and 6 carries.
// The core pops a new command only from idle, so it finishes one block before the next;
//   the queue holds up to two commands meanwhile.
// Synchronous active-low reset clears keys, accumulator, fill count and queue.
// ----------------------------------------------------------------------------
// poly1305_mac_unit
// Poly1305 one-time authenticator: chunk packing front end, command queue
// and modular arithmetic core.
// ----------------------------------------------------------------------------
module poly1305_mac_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_chunk_valid,
    output logic             o_chunk_ready,
    input  poly_pkg::t_chunk i_chunk,
    output logic             o_tag_valid,
    input  logic             i_tag_ready,
    output poly_pkg::t_tag   o_tag
);

    poly_pkg::t_key r_key;
    logic           push, fifo_ready, cmd_valid, cmd_pop;
    poly_pkg::t_cmd push_cmd, cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                poly_pkg::CFG_R_LO: r_key.r_lo <= i_cfg_data;
                poly_pkg::CFG_R_HI: r_key.r_hi <= i_cfg_data;
                poly_pkg::CFG_S_LO: r_key.s_lo <= i_cfg_data;
                poly_pkg::CFG_S_HI: r_key.s_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    poly_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chunk_valid (i_chunk_valid),
        .o_chunk_ready (o_chunk_ready),
        .i_chunk       (i_chunk),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_fifo_ready  (fifo_ready)
    );

    poly_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (fifo_ready),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd)
    );

    poly_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_tag_valid (o_tag_valid),
        .i_tag_ready (i_tag_ready),
        .o_tag       (o_tag)
    );

endmodule

// File: rtl/poly_fifo.sv
// ----------------------------------------------------------------------------
// poly_fifo
// Two-entry command queue between the front end and the arithmetic core.
// ----------------------------------------------------------------------------
module poly_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  poly_pkg::t_cmd i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output poly_pkg::t_cmd o_data
);

    poly_pkg::t_cmd r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) r_wptr <= ~r_wptr;
            if (do_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: rtl/poly_front.sv
// ----------------------------------------------------------------------------
// poly_front
// Packs message chunks into 16-byte blocks and issues core commands.
// ----------------------------------------------------------------------------
module poly_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_chunk_valid,
    output logic             o_chunk_ready,
    input  poly_pkg::t_chunk i_chunk,
    output logic             o_push,
    output poly_pkg::t_cmd   o_cmd,
    input  logic             i_fifo_ready
);

    logic [127:0]   r_buf;
    logic [4:0]     r_fill;
    logic           r_pend_vld;
    poly_pkg::t_cmd r_pend;

    logic [3:0]     nb;
    logic [63:0]    dmask;
    logic [127:0]   bmask;
    logic [191:0]   comb;
    logic [4:0]     total;
    logic           full, last, accept;
    logic [127:0]   n_buf;
    logic [4:0]     n_fill;
    poly_pkg::t_cmd cmd_a, cmd_b;

    always_comb begin
        nb     = (i_chunk.chunk_bytes > poly_pkg::MAX_BYTES) ? poly_pkg::MAX_BYTES
                                                            : i_chunk.chunk_bytes;
        dmask  = (64'd1 << {nb, 3'b000}) - 64'd1;
        bmask  = (128'd1 << {r_fill[3:0], 3'b000}) - 128'd1;
        comb   = {64'd0, r_buf & bmask}
               | ({128'd0, i_chunk.chunk_data & dmask} << {r_fill[3:0], 3'b000});
        total  = r_fill + {1'b0, nb};
        full   = (total >= poly_pkg::BLOCK_BYTES);
        last   = i_chunk.last_chunk;
        n_buf  = full ? {64'd0, comb[191:128]} : comb[127:0];
        n_fill = full ? (total - poly_pkg::BLOCK_BYTES) : total;

        cmd_a.blk    = comb[127:0];
        cmd_a.absorb = 1'b1;
        cmd_a.hibit  = 1'b1;
        cmd_a.fin    = 1'b0;

        // Pad a partial block with a one byte right after the data.
        cmd_b.blk    = n_buf | (128'd1 << {n_fill[3:0], 3'b000});
        cmd_b.absorb = (n_fill != 5'd0);
        cmd_b.hibit  = 1'b0;
        cmd_b.fin    = 1'b1;
    end

    assign o_chunk_ready = !r_pend_vld && i_fifo_ready;
    assign accept        = i_chunk_valid && o_chunk_ready;
    assign o_push        = r_pend_vld || (accept && (full || last));
    assign o_cmd         = r_pend_vld ? r_pend : (full ? cmd_a : cmd_b);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
            if (full && last) r_pend <= cmd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= 5'd0;
            r_pend_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_fill     <= last ? 5'd0 : n_fill;
                r_pend_vld <= full && last;
            end else if (r_pend_vld && i_fifo_ready) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/poly_core.sv
// ----------------------------------------------------------------------------
// poly_core
// Accumulate-and-multiply modulo 2^130-5 on one shared limb multiplier,
// then final reduction and addition of s.
// ----------------------------------------------------------------------------
module poly_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  poly_pkg::t_key i_key,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  poly_pkg::t_cmd i_cmd,
    output logic           o_tag_valid,
    input  logic           i_tag_ready,
    output poly_pkg::t_tag o_tag
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CARRY = 3'd3;
    localparam logic [2:0] S_FSUB  = 3'd4;
    localparam logic [2:0] S_TAG   = 3'd5;

    logic [2:0]        r_state;
    poly_pkg::t_cmd    r_cmd;
    logic              r_finishing;
    logic [26:0]       r_acc [5];
    logic [26:0]       r_h   [5];
    logic [25:0]       r_rl  [5];
    logic [59:0]       r_d   [5];
    logic [2:0]        r_i, r_j, r_pi, r_s;
    logic              r_issue, r_prod_vld;
    logic [55:0]       r_prod;
    logic [3:0]        r_left;
    logic [127:0]      r_res;
    logic              r_out_vld;
    poly_pkg::t_tag    r_out;

    poly_pkg::t_limbs  nl, rl;
    logic [26:0]       h [5];
    logic [28:0]       sum;
    logic [2:0]        c3;
    logic [29:0]       h0x;
    logic [2:0]        kk;
    logic [28:0]       rop;
    logic [33:0]       cy;
    logic [59:0]       gv [5];
    logic [59:0]       hs [5];
    logic [59:0]       gc;
    logic [63:0]       lo, hi;
    logic [127:0]      tag;

    // Block plus accumulator, one carry pass with the top folded back.
    always_comb begin
        nl = poly_pkg::split_limbs(r_cmd.blk[63:0], r_cmd.blk[127:64]);
        if (r_cmd.hibit) nl[4] = nl[4] | poly_pkg::TOP_BIT;
        rl = poly_pkg::split_limbs(i_key.r_lo & poly_pkg::R_CLAMP_LO,
                                   i_key.r_hi & poly_pkg::R_CLAMP_HI);
        c3 = 3'd0;
        for (int k = 0; k < 5; k++) begin
            sum  = {2'b00, r_acc[k]} + {3'b000, nl[k]} + {26'd0, c3};
            h[k] = {1'b0, sum[25:0]};
            c3   = sum[28:26];
        end
        h0x  = {4'd0, h[0][25:0]} + {25'd0, c3, 2'b00} + {27'd0, c3};
        h[0] = {1'b0, h0x[25:0]};
        h[1] = h[1] + {23'd0, h0x[29:26]};
    end

    // Limb of r for product h[j]*r[i-j], wrapped terms scaled by five.
    always_comb begin
        kk  = (r_i >= r_j) ? (r_i - r_j) : (r_i + 3'd5 - r_j);
        rop = (r_i >= r_j) ? {3'b000, r_rl[kk]}
                           : ({1'b0, r_rl[kk], 2'b00} + {3'b000, r_rl[kk]});
        cy  = r_d[r_s][59:26];
    end

    // Final conditional subtraction of p and addition of s.
    always_comb begin
        for (int k = 0; k < 5; k++) hs[k] = r_d[k];
        gc = 60'd5;
        for (int k = 0; k < 5; k++) begin
            gv[k] = hs[k] + gc;
            gc    = {26'd0, gv[k][59:26]};
            gv[k] = {34'd0, gv[k][25:0]};
        end
        if (gc != 60'd0) begin
            for (int k = 0; k < 5; k++) hs[k] = gv[k];
        end
        lo  = {4'd0, hs[0]} | ({4'd0, hs[1]} << 26) | ({4'd0, hs[2]} << 52);
        hi  = ({4'd0, hs[2]} >> 12) | ({4'd0, hs[3]} << 14) | ({4'd0, hs[4]} << 40);
        tag = {hi, lo} + {i_key.s_hi, i_key.s_lo};
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_tag_valid = r_out_vld;
    assign o_tag       = r_out;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (r_state == S_ADD) begin
            for (int k = 0; k < 5; k++) begin
                r_h[k]  <= h[k];
                r_rl[k] <= rl[k];
                r_d[k]  <= 60'd0;
            end
        end
        if (o_cmd_pop && !i_cmd.absorb) begin
            for (int k = 0; k < 5; k++) r_d[k] <= {33'd0, r_acc[k]};
        end
        if (r_issue) begin
            r_prod <= r_h[r_j] * rop;
            r_pi   <= r_i;
        end
        if (r_prod_vld) r_d[r_pi] <= r_d[r_pi] + {4'd0, r_prod};
        if (r_state == S_CARRY) begin
            if (r_s == 3'd4) begin
                r_d[4] <= {34'd0, r_d[4][25:0]};
                r_d[0] <= r_d[0] + {24'd0, cy, 2'b00} + {26'd0, cy};
            end else begin
                r_d[r_s]        <= {34'd0, r_d[r_s][25:0]};
                r_d[r_s + 3'd1] <= r_d[r_s + 3'd1] + {26'd0, cy};
            end
        end
        if (r_state == S_FSUB) r_res <= tag;
        if (r_state == S_TAG && (!r_out_vld || i_tag_ready)) begin
            r_out.tag_low  <= r_res[63:0];
            r_out.tag_high <= r_res[127:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finishing <= 1'b0;
            r_issue     <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_i         <= 3'd0;
            r_j         <= 3'd0;
            r_s         <= 3'd0;
            r_left      <= 4'd0;
            r_out_vld   <= 1'b0;
            for (int k = 0; k < 5; k++) r_acc[k] <= 27'd0;
        end else begin
            r_prod_vld <= r_issue;
            r_out_vld  <= (r_state == S_TAG) || (r_out_vld && !i_tag_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_finishing <= !i_cmd.absorb;
                        r_s         <= 3'd0;
                        r_left      <= 4'd15;
                        r_state     <= i_cmd.absorb ? S_ADD : S_CARRY;
                    end
                end
                S_ADD: begin
                    r_i     <= 3'd0;
                    r_j     <= 3'd0;
                    r_issue <= 1'b1;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_issue) begin
                        if (r_j == 3'd4) begin
                            r_j <= 3'd0;
                            r_i <= r_i + 3'd1;
                            if (r_i == 3'd4) r_issue <= 1'b0;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end else if (!r_prod_vld) begin
                        r_s     <= 3'd0;
                        r_left  <= 4'd6;
                        r_state <= S_CARRY;
                    end
                end
                S_CARRY: begin
                    if (r_left == 4'd1) begin
                        if (r_finishing) begin
                            r_state <= S_FSUB;
                        end else begin
                            // Take the limbs with this cycle's carry out of limb zero applied.
                            r_acc[0] <= {1'b0, r_d[0][25:0]};
                            r_acc[1] <= r_d[1][26:0] + cy[26:0];
                            for (int k = 2; k < 5; k++) r_acc[k] <= r_d[k][26:0];
                            if (r_cmd.fin) begin
                                // Keep the fresh product in place and run the final passes.
                                r_finishing <= 1'b1;
                                r_s         <= 3'd0;
                                r_left      <= 4'd15;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_s    <= (r_s == 3'd4) ? 3'd0 : r_s + 3'd1;
                        r_left <= r_left - 4'd1;
                    end
                end
                S_FSUB: begin
                    for (int k = 0; k < 5; k++) r_acc[k] <= 27'd0;
                    r_state <= S_TAG;
                end
                S_TAG: begin
                    if (!r_out_vld || i_tag_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/poly_checker.sv
// ----------------------------------------------------------------------------
// poly_checker
// Port-level checks on the Poly1305 MAC unit.
// ----------------------------------------------------------------------------
`include "poly1305_mac_unit_defines.svh"

module poly_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_cfg_ready,
    input logic             o_tag_valid,
    input logic             i_tag_ready,
    input poly_pkg::t_tag   o_tag
);

    `POLY_CHECK(a_tag_hold, o_tag_valid && !i_tag_ready |=> o_tag_valid, "tag beat dropped")
    `POLY_CHECK(a_tag_stable, o_tag_valid && !i_tag_ready |=> $stable(o_tag), "tag changed")
    `POLY_CHECK_ALWAYS(a_no_tag_reset, !i_rst_n |=> !o_tag_valid, "tag after reset")
    `POLY_CHECK(a_cfg_ready, o_cfg_ready, "config port stalled")

endmodule

bind poly1305_mac_unit poly_checker u_checker (.*);
